@@ rtl/core/assert_macros.svh @@
// assertion helpers for the core modules, included by pttt_seq
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define PTTT_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define PTTT_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`endif

@@ rtl/core/pttt_pkg.sv @@
package pttt_pkg;

  localparam int TASK_SLOTS_DEF = 8;

  localparam int KEY_W  = 16;
  localparam int IVAL_W = 16;
  localparam int MS_W   = 8;
  localparam int SLOT_W = 5;
  localparam int CNT_W  = 6;
  localparam int STAT_W = 4;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_CREATE  = 2'd1,
    ACT_DELETE  = 2'd2,
    ACT_COLLECT = 2'd3
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_TICK  = 4'd0,
    ST_ADD   = 4'd1,
    ST_UPD   = 4'd2,
    ST_FULL  = 4'd3,
    ST_IGN   = 4'd4,
    ST_REM   = 4'd5,
    ST_NF    = 4'd6,
    ST_PEND  = 4'd7,
    ST_NONE  = 4'd8
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_EMIT,
    S_CSEL,
    S_CEMIT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [IVAL_W-1:0] ival;
    logic [IVAL_W-1:0] cd;
  } entry_t;

endpackage

@@ rtl/core/periodic_task_tick_table_core.sv @@
// channel  | direction | handshake           | payload
// in_      | slave     | in_tvalid/tready    | tuser action, tdata key and interval
// out_     | master    | out_tvalid/tready   | tuser status, tdata key/slot/wake/count, tlast
// cfg_     | apb       | psel/penable, ready | ms_per_tick at byte address 0
//
// for tick, delete and an accepted create the sequencer walks the table one slot per
// cycle through the single read port of the memory
// collect emits one result per pending task, lowest slot first, or one with none pending
// reset is synchronous, active low; table contents are kept; state, count and flags clear
// a new item is taken once the previous result sits in the output register,
// so a stalled out_tready holds the block after at most one waiting result
module periodic_task_tick_table_core
  import pttt_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // task_key, interval
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // task_key_res, slot, wake, task_count, zero pad
  output logic [3:0]  out_tuser,  // status
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);

  logic [MS_W-1:0]   ms_per_tick;
  logic [AW-1:0]     mem_raddr;
  logic [AW-1:0]     mem_waddr;
  logic              mem_we;
  entry_t            mem_rdata;
  entry_t            mem_wdata;
  stat_t             out_status;
  logic [KEY_W-1:0]  out_key;
  logic [SLOT_W-1:0] out_slot;
  logic              out_wake;
  logic [CNT_W-1:0]  out_count;

  pttt_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .ms_per_tick (ms_per_tick)
  );

  pttt_mem #(
    .DEPTH (TASK_SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pttt_seq #(
    .TASK_SLOTS (TASK_SLOTS),
    .AW         (AW),
    .CW         (CW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_action   (act_t'(in_tuser)),
    .in_key      (in_tdata[15:0]),
    .in_ival     (in_tdata[31:16]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_status  (out_status),
    .out_key     (out_key),
    .out_slot    (out_slot),
    .out_wake    (out_wake),
    .out_count   (out_count),
    .out_last    (out_tlast),
    .ms_per_tick (ms_per_tick),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata)
  );

  assign out_tuser = out_status;
  assign out_tdata = {4'h0, out_count, out_wake, out_slot, out_key};

endmodule

@@ rtl/core/pttt_mem.sv @@
module pttt_mem
  import pttt_pkg::*;
#(
  parameter int DEPTH = TASK_SLOTS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/pttt_cfg.sv @@
module pttt_cfg
  import pttt_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_psel,
  input  logic            cfg_penable,
  input  logic            cfg_pwrite,
  input  logic [2:0]      cfg_paddr,
  input  logic [31:0]     cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready,
  output logic [MS_W-1:0] ms_per_tick
);

  localparam logic REG_MS_PER_TICK = 1'b0;

  logic [MS_W-1:0] ms_r;
  logic [MS_W-1:0] ms_nxt;
  logic            sel_ms;

  // byte address bit 2 picks the register, low bits ignored
  assign sel_ms = (cfg_paddr[2] == REG_MS_PER_TICK);

  always_comb begin
    ms_nxt = ms_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && sel_ms) begin
      ms_nxt = cfg_pwdata[MS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r <= MS_W'(1);
    end else begin
      ms_r <= ms_nxt;
    end
  end

  assign cfg_pready  = 1'b1;
  assign cfg_prdata  = sel_ms ? {{(32-MS_W){1'b0}}, ms_r} : 32'h0;
  assign ms_per_tick = ms_r;

endmodule

@@ rtl/core/pttt_seq.sv @@
`include "assert_macros.svh"
module pttt_seq
  import pttt_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF,
  parameter int AW         = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1,
  parameter int CW         = $clog2(TASK_SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  act_t              in_action,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [IVAL_W-1:0] in_ival,
  output logic              out_tvalid,
  input  logic              out_tready,
  output stat_t             out_status,
  output logic [KEY_W-1:0]  out_key,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_wake,
  output logic [CNT_W-1:0]  out_count,
  output logic              out_last,
  input  logic [MS_W-1:0]   ms_per_tick,
  output logic [AW-1:0]     mem_raddr,
  input  entry_t            mem_rdata,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output entry_t            mem_wdata
);

  state_t state_r, state_nxt;

  act_t              act_r, act_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [IVAL_W-1:0] ival_r, ival_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              found_r, found_nxt;
  logic              wake_r, wake_nxt;
  stat_t             stat_r, stat_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [TASK_SLOTS-1:0] pend_r, pend_nxt;

  logic              ov_r, ov_nxt;
  stat_t             ostat_r, ostat_nxt;
  logic [KEY_W-1:0]  okey_r, okey_nxt;
  logic [SLOT_W-1:0] oslot_r, oslot_nxt;
  logic              owake_r, owake_nxt;
  logic [CNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic              olast_r, olast_nxt;

  logic              in_acc;
  logic              out_free;
  logic              at_end;
  logic              hit;
  logic              bad_req;
  logic              full;
  logic              pend_any;
  logic [AW-1:0]     pick;
  logic [AW-1:0]     idx_a;
  logic [AW-1:0]     idx_dec;
  logic [AW-1:0]     cnt_a;
  logic [AW-1:0]     cnt_dec;
  logic [CW-1:0]     idx_inc;
  logic [TASK_SLOTS-1:0] pend_oth;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !ov_r || out_tready;
  assign at_end   = (idx_r == cnt_r);
  assign hit      = (mem_rdata.key == key_r);
  assign bad_req  = (in_key == '0) || (in_ival == '0);
  assign full     = (cnt_r == CW'(TASK_SLOTS));
  assign pend_any = |pend_r;
  assign idx_a    = idx_r[AW-1:0];
  assign idx_dec  = idx_a - AW'(1);
  assign cnt_a    = cnt_r[AW-1:0];
  assign cnt_dec  = cnt_a - AW'(1);
  assign idx_inc  = idx_r + CW'(1);

  // lowest pending slot
  always_comb begin
    pick = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        pick = AW'(i);
      end
    end
  end

  always_comb begin
    pend_oth        = pend_r;
    pend_oth[idx_a] = 1'b0;
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_action)
            ACT_TICK, ACT_DELETE: state_nxt = S_WALK;
            ACT_CREATE:           state_nxt = (bad_req || full) ? S_EMIT : S_WALK;
            ACT_COLLECT:          state_nxt = S_CSEL;
          endcase
        end
      end
      S_WALK: begin
        if (at_end || (act_r == ACT_CREATE && hit)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_CSEL: begin
        state_nxt = pend_any ? S_CEMIT : S_EMIT;
      end
      S_CEMIT: begin
        if (out_free) begin
          state_nxt = (pend_oth == '0) ? S_IDLE : S_CSEL;
        end
      end
    endcase
  end

  always_comb begin
    act_nxt   = act_r;
    key_nxt   = key_r;
    ival_nxt  = ival_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    wake_nxt  = wake_r;
    stat_nxt  = stat_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;

    ov_nxt    = ov_r && !out_tready;
    ostat_nxt = ostat_r;
    okey_nxt  = okey_r;
    oslot_nxt = oslot_r;
    owake_nxt = owake_r;
    ocnt_nxt  = ocnt_r;
    olast_nxt = olast_r;

    mem_raddr = idx_a;
    mem_we    = 1'b0;
    mem_waddr = idx_a;
    mem_wdata = mem_rdata;

    unique case (state_r)
      S_IDLE: begin
        mem_raddr = '0;
        if (in_acc) begin
          act_nxt   = in_action;
          key_nxt   = in_key;
          ival_nxt  = in_ival;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          wake_nxt  = 1'b0;
          stat_nxt  = bad_req ? ST_IGN : ST_FULL;
        end
      end
      S_WALK: begin
        // read one slot ahead; writes only land on slots already read
        mem_raddr = idx_inc[AW-1:0];
        idx_nxt   = idx_inc;
        if (!at_end) begin
          unique case (act_r)
            ACT_TICK: begin
              mem_we = 1'b1;
              if (mem_rdata.cd > {{(IVAL_W-MS_W){1'b0}}, ms_per_tick}) begin
                mem_wdata.cd = mem_rdata.cd - {{(IVAL_W-MS_W){1'b0}}, ms_per_tick};
              end else begin
                mem_wdata.cd    = mem_rdata.ival;
                pend_nxt[idx_a] = 1'b1;
                wake_nxt        = 1'b1;
              end
            end
            ACT_CREATE: begin
              if (hit) begin
                mem_we         = 1'b1;
                mem_wdata.ival = ival_r;
                stat_nxt       = ST_UPD;
              end
            end
            ACT_DELETE: begin
              if (found_r) begin
                mem_we            = 1'b1;
                mem_waddr         = idx_dec;
                pend_nxt[idx_dec] = pend_r[idx_a];
              end else if (hit) begin
                found_nxt = 1'b1;
              end
            end
            ACT_COLLECT: begin
            end
          endcase
        end else begin
          unique case (act_r)
            ACT_TICK: begin
              stat_nxt = ST_TICK;
            end
            ACT_CREATE: begin
              mem_we          = 1'b1;
              mem_waddr       = cnt_a;
              mem_wdata       = '{key: key_r, ival: ival_r, cd: ival_r};
              pend_nxt[cnt_a] = 1'b0;
              cnt_nxt         = cnt_r + CW'(1);
              stat_nxt        = ST_ADD;
            end
            ACT_DELETE: begin
              if (found_r) begin
                pend_nxt[cnt_dec] = 1'b0;
                cnt_nxt           = cnt_r - CW'(1);
                stat_nxt          = ST_REM;
              end else begin
                stat_nxt = ST_NF;
              end
            end
            ACT_COLLECT: begin
            end
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ostat_nxt = stat_r;
          okey_nxt  = '0;
          oslot_nxt = '0;
          owake_nxt = wake_r;
          ocnt_nxt  = CNT_W'(cnt_r);
          olast_nxt = 1'b1;
        end
      end
      S_CSEL: begin
        mem_raddr = pick;
        idx_nxt   = CW'(pick);
        stat_nxt  = ST_NONE;
      end
      S_CEMIT: begin
        if (out_free) begin
          ov_nxt          = 1'b1;
          ostat_nxt       = ST_PEND;
          okey_nxt        = mem_rdata.key;
          oslot_nxt       = SLOT_W'(idx_a);
          owake_nxt       = 1'b0;
          ocnt_nxt        = CNT_W'(cnt_r);
          olast_nxt       = (pend_oth == '0);
          pend_nxt[idx_a] = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    key_r   <= key_nxt;
    ival_r  <= ival_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    wake_r  <= wake_nxt;
    stat_r  <= stat_nxt;
    ostat_r <= ostat_nxt;
    okey_r  <= okey_nxt;
    oslot_r <= oslot_nxt;
    owake_r <= owake_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_status = ostat_r;
  assign out_key    = okey_r;
  assign out_slot   = oslot_r;
  assign out_wake   = owake_r;
  assign out_count  = ocnt_r;
  assign out_last   = olast_r;

  `PTTT_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CW'(TASK_SLOTS), "task count above table size")
  `PTTT_ASSERT(a_pend_range, clk, rst_n, (pend_r >> cnt_r) == '0, "pending flag beyond task count")
  `PTTT_ASSERT(a_done_has_result, clk, rst_n, (state_r != S_IDLE && state_nxt == S_IDLE) |=> ov_r, "item finished without a result")

endmodule
